FILE: hw/rtl/bdqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_pkg
// Shared types and codes for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdqs_pkg;

   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic shift_up;    // take the entry of the cell in front
      logic shift_down;  // take the entry of the cell behind
      logic load;        // take the request value (insert at back)
      logic kill;        // drop the search probe
   } cell_ctl_type;

endpackage

FILE: hw/rtl/bdqs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_cell
// One deque slot: holds an entry, shifts with its neighbors and compares
// the search key while the probe sits here.
// ----------------------------------------------------------------------------
module bdqs_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  bdqs_pkg::cell_ctl_type             ctl,
   input  logic [bdqs_pkg::DATA_W-1:0]        up_entry,
   input  logic [bdqs_pkg::DATA_W-1:0]        down_entry,
   input  logic [bdqs_pkg::DATA_W-1:0]        load_value,
   input  logic [bdqs_pkg::DATA_W-1:0]        key,
   input  logic                               probe_in,
   output logic [bdqs_pkg::DATA_W-1:0]        entry,
   output logic                               probe,
   output logic                               hit
);

   logic [bdqs_pkg::DATA_W-1:0] entry_ff;
   logic [bdqs_pkg::DATA_W-1:0] entry_in;
   logic                        probe_ff;
   logic                        probe_in_w;

   always_comb begin
      priority if (ctl.shift_up) begin
         entry_in = up_entry;
      end else if (ctl.shift_down) begin
         entry_in = down_entry;
      end else if (ctl.load) begin
         entry_in = load_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   assign probe_in_w = probe_in & ~ctl.kill;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= 1'b0;
      end else begin
         probe_ff <= probe_in_w;
      end
   end

   assign entry = entry_ff;
   assign probe = probe_ff;
   assign hit   = probe_ff & (entry_ff == key);

endmodule

FILE: hw/rtl/bounded_deque_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Bounded deque of signed 32-bit values held in a chain of cells, with a
// linear search that walks a probe from the front cell toward the back.
// ----------------------------------------------------------------------------
//   channel   ports                            transfer
//   request   req_start, req_opcode, req_value  req_start high while busy low
//   response  rsp_valid, rsp_status,            rsp_valid high, one cycle
//             rsp_position
//
// An insert or delete is answered in the cycle after it is taken, and a new
// request may be issued there. A search moves the probe one cell per cycle
// until it finds a match or reaches the last stored entry; busy is high
// until the response. Reset empties the deque; entries need no clearing.
// The response cannot be stalled.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_start,
   input  logic [bdqs_pkg::OP_W-1:0]            req_opcode,
   input  logic signed [bdqs_pkg::DATA_W-1:0]   req_value,
   output logic                                 busy,
   output logic                                 rsp_valid,
   output logic [bdqs_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bdqs_pkg::POS_W-1:0]           rsp_position
);

   localparam int CW  = $clog2(DEPTH + 1);
   localparam int SW  = $clog2(DEPTH);
   localparam int SW1 = SW + 1;

   logic [CW-1:0]                 count_ff, count_in;
   logic [SW-1:0]                 scan_ff, scan_in;
   logic                          busy_ff, busy_in;
   logic [bdqs_pkg::DATA_W-1:0]   key_ff, key_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bdqs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bdqs_pkg::POS_W-1:0]    rsp_position_ff, rsp_position_in;

   logic                          accept;
   logic                          is_full;
   logic                          is_empty;
   logic                          do_shift_up;
   logic                          do_shift_down;
   logic                          do_load_back;
   logic                          launch;
   logic                          kill;
   logic                          any_hit;
   logic                          last_scan;
   logic [SW1-1:0]                scan_next;

   logic [DEPTH-1:0]              hit_vec;
   logic [DEPTH-1:0]              probe_vec;
   logic [bdqs_pkg::DATA_W-1:0]   entry_vec [DEPTH];

   assign accept    = req_start & ~busy_ff;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign any_hit   = |hit_vec;
   assign scan_next = SW1'(scan_ff) + SW1'(1);
   assign last_scan = (scan_next == SW1'(count_ff));

   always_comb begin
      count_in        = count_ff;
      scan_in         = scan_ff;
      busy_in         = busy_ff;
      key_in          = key_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = bdqs_pkg::ST_OK;
      rsp_position_in = '0;
      do_shift_up     = 1'b0;
      do_shift_down   = 1'b0;
      do_load_back    = 1'b0;
      launch          = 1'b0;
      kill            = 1'b0;
      if (busy_ff) begin
         // search walking the chain
         if (any_hit) begin
            busy_in         = 1'b0;
            kill            = 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = bdqs_pkg::ST_OK;
            rsp_position_in = bdqs_pkg::POS_W'(scan_next);
         end else if (last_scan) begin
            busy_in       = 1'b0;
            kill          = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = bdqs_pkg::ST_NOTFOUND;
         end else begin
            scan_in = scan_next[SW-1:0];
         end
      end else if (accept) begin
         unique case (req_opcode)
            bdqs_pkg::OP_INS_FRONT: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = bdqs_pkg::ST_FULL;
               end else begin
                  do_shift_up = 1'b1;
                  count_in    = count_ff + CW'(1);
               end
            end
            bdqs_pkg::OP_INS_BACK: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = bdqs_pkg::ST_FULL;
               end else begin
                  do_load_back = 1'b1;
                  count_in     = count_ff + CW'(1);
               end
            end
            bdqs_pkg::OP_DEL_FRONT: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = bdqs_pkg::ST_EMPTY;
               end else begin
                  do_shift_down = 1'b1;
                  count_in      = count_ff - CW'(1);
               end
            end
            bdqs_pkg::OP_DEL_BACK: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = bdqs_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            bdqs_pkg::OP_SEARCH: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bdqs_pkg::ST_EMPTY;
               end else begin
                  // launch the probe into the front cell
                  launch  = 1'b1;
                  busy_in = 1'b1;
                  scan_in = '0;
                  key_in  = req_value;
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bdqs_pkg::cell_ctl_type       ctl;
      logic [bdqs_pkg::DATA_W-1:0] up_entry;
      logic [bdqs_pkg::DATA_W-1:0] down_entry;
      logic                        probe_in;

      assign ctl.shift_up   = do_shift_up;
      assign ctl.shift_down = do_shift_down;
      assign ctl.load       = do_load_back & (count_ff == CW'(i));
      assign ctl.kill       = kill;

      if (i == 0) begin : g_front
         assign up_entry = req_value;
         assign probe_in = launch;
      end else begin : g_inner
         assign up_entry = entry_vec[i-1];
         assign probe_in = probe_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign down_entry = entry_vec[i];
      end else begin : g_mid
         assign down_entry = entry_vec[i+1];
      end

      bdqs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .up_entry   (up_entry),
         .down_entry (down_entry),
         .load_value (req_value),
         .key        (key_ff),
         .probe_in   (probe_in),
         .entry      (entry_vec[i]),
         .probe      (probe_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff         <= scan_in;
      key_ff          <= key_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;

endmodule

FILE: hw/rtl/bdqs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_checker
// Port-level checks for the bounded deque with search.
// ----------------------------------------------------------------------------
module bdqs_checker #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_start,
   input  logic [bdqs_pkg::OP_W-1:0]            req_opcode,
   input  logic                                 busy,
   input  logic                                 rsp_valid,
   input  logic [bdqs_pkg::STATUS_W-1:0]        rsp_status,
   input  logic [bdqs_pkg::POS_W-1:0]           rsp_position
);

   // a failed operation never reports a position
   a_pos_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bdqs_pkg::ST_OK) |-> (rsp_position == '0))
      else $error("position set on a failing status");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_position) <= 32'(DEPTH)))
      else $error("position beyond the deque depth");

   // single-step operations answer in the next cycle and leave busy low
   a_single_step: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && req_opcode != bdqs_pkg::OP_SEARCH)
      |=> (rsp_valid && !busy))
      else $error("single-step transfer without a response");

   // a search ends with its response
   a_search_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> !$past(rsp_valid))
      else $error("response while a search was still running");

endmodule

bind bounded_deque_with_search_core bdqs_checker #(.DEPTH(DEPTH)) u_bdqs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_start    (req_start),
   .req_opcode   (req_opcode),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position)
);

FILE: tb/sv/tb_bounded_deque_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search_core
// Self-checking bench for the bounded deque: drives insert, delete, search and
// unused opcodes with random idle gaps, predicts each status and match position
// from a local copy of the deque, and checks every response in order.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search_core;
   import bdqs_pkg::*;

   localparam int DEPTH         = 16;
   localparam int RANDOM_ITEMS  = 1825;
   localparam int BURST_LEN     = 25;
   localparam int MAX_GAP       = 12;
   localparam int TAIL_CYCLES   = DEPTH + 8;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
   } deque_rsp_type;

   // Deque predictor plus queue of responses still owed by the block
   class deque_scoreboard;
      logic [DATA_W-1:0] slots[DEPTH];
      int unsigned       fill;
      deque_rsp_type     owed_q[$];
      int unsigned       errors;

      function void note_request(logic [OP_W-1:0] opcode, logic [DATA_W-1:0] value);
         deque_rsp_type rsp;
         rsp.status   = ST_OK;
         rsp.position = '0;
         case (opcode)
            OP_INS_FRONT: begin
               if (fill >= DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  for (int k = fill; k > 0; k--) slots[k] = slots[k-1];
                  slots[0] = value;
                  fill++;
               end
            end
            OP_INS_BACK: begin
               if (fill >= DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  slots[fill] = value;
                  fill++;
               end
            end
            OP_DEL_FRONT: begin
               if (fill == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  for (int k = 0; k + 1 < fill; k++) slots[k] = slots[k+1];
                  fill--;
               end
            end
            OP_DEL_BACK: begin
               if (fill == 0) rsp.status = ST_EMPTY;
               else fill--;
            end
            OP_SEARCH: begin
               if (fill == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  rsp.status = ST_NOTFOUND;
                  // first match from the front, back entry included
                  for (int k = 0; k < fill; k++) begin
                     if (slots[k] == value) begin
                        rsp.status   = ST_OK;
                        rsp.position = POS_W'(k + 1);
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         owed_q.push_back(rsp);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position);
         deque_rsp_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected response status %0d position %0d",
                     $time, status, position);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (status !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, want.status, status);
            errors++;
         end
         if (position !== want.position) begin
            $display("%0t: position mismatch expected %0d actual %0d",
                     $time, want.position, position);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_start = 1'b0;
   logic [OP_W-1:0]            req_opcode = OP_INS_FRONT;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic [POS_W-1:0]           rsp_position;

   deque_scoreboard store = new();
   int unsigned     idle_mode = 0;

   bounded_deque_with_search_core #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_start    (req_start),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) store.check_response(rsp_status, rsp_position);
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Hold the command until the block takes it, then log the transfer
   task automatic send_item(input logic [OP_W-1:0] opcode, input logic [DATA_W-1:0] value);
      int unsigned gap;
      case (idle_mode)
         0: gap = 0;
         1: gap = $urandom_range(0, MAX_GAP);
         default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      endcase
      if (gap != 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start  <= 1'b1;
      req_opcode <= opcode;
      req_value  <= value;
      do @(posedge clock); while (busy);
      store.note_request(opcode, value);
   endtask

   // Stop issuing until every owed response has come back
   task automatic drain();
      req_start <= 1'b0;
      do @(posedge clock); while (store.pending() != 0);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return DATA_W'($signed($urandom_range(0, 7)) - 4);
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic run_directed();
      logic [DATA_W-1:0] fill_vals[DEPTH];
      fill_vals = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                    32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF,
                    32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
      // empty deque
      send_item(OP_SEARCH, 32'h0000_0005);
      send_item(OP_DEL_FRONT, 32'hFFFF_FFFF);
      send_item(OP_DEL_BACK, 32'h0000_0000);
      send_item(OP_SPARE_HI, 32'h8000_0000);
      // fill from both ends, back entry ends up as the max value
      for (int k = 0; k < DEPTH; k++)
         send_item(k[0] ? OP_INS_BACK : OP_INS_FRONT, fill_vals[k]);
      send_item(OP_INS_FRONT, 32'h0000_0042);
      send_item(OP_INS_BACK, 32'h0000_0043);
      send_item(OP_SEARCH, 32'h7FFF_FFFF);
      send_item(OP_SEARCH, 32'h0000_0000);
      send_item(OP_SEARCH, 32'h0BAD_F00D);
   endtask

   task automatic run_random();
      int unsigned counted;
      int unsigned ins_pct;
      int unsigned roll;
      int unsigned bursts;
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] value;
      counted = 0;
      bursts  = 0;
      while (counted < RANDOM_ITEMS) begin
         // sweep the fill level by shifting the insert/delete balance
         case ($urandom_range(0, 4))
            0: ins_pct = 10;
            1: ins_pct = 30;
            2: ins_pct = 50;
            3: ins_pct = 70;
            default: ins_pct = 90;
         endcase
         idle_mode = $urandom_range(0, 2);
         for (int n = 0; n < BURST_LEN; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               opcode = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
               value  = $urandom();
            end else if (roll < 33) begin
               opcode = OP_SEARCH;
               if (store.fill != 0 && $urandom_range(0, 2) != 0)
                  value = store.slots[$urandom_range(0, store.fill - 1)];
               else
                  value = pick_value();
            end else begin
               value = pick_value();
               if ($urandom_range(0, 99) < ins_pct)
                  opcode = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
               else
                  opcode = $urandom_range(0, 1) ? OP_DEL_BACK : OP_DEL_FRONT;
            end
            send_item(opcode, value);
            if (opcode < OP_SPARE_LO) counted++;
         end
         bursts++;
         if (bursts % 9 == 0) drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain();
      run_random();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (store.pending() != 0) begin
         $display("%0t: %0d responses never arrived", $time, store.pending());
         store.errors++;
      end
      if (store.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
